/* src/apaf_pkg.sv */
// ----------------------------------------------------------------------------
// apaf_pkg
// shared types and constants of the address prefix access filter
// ----------------------------------------------------------------------------
package apaf_pkg;

  localparam int unsigned LIST_DEPTH     = 16;
  localparam int unsigned MAX_TEXT_CHARS = 15;

  localparam int unsigned TextW   = 8 * MAX_TEXT_CHARS;
  localparam int unsigned HeadW   = 64;
  localparam int unsigned TailW   = 56;
  localparam int unsigned LenW    = 5;
  localparam int unsigned ELenW   = 4;
  localparam int unsigned EntryW  = TextW + ELenW;
  localparam int unsigned Slots   = 2 * LIST_DEPTH;
  localparam int unsigned SlotW   = $clog2(Slots);
  localparam int unsigned CntW    = $clog2(LIST_DEPTH + 1);
  localparam int unsigned InDataW = 128;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 2;

  typedef enum logic [1:0] {
    CMD_ADD_SVC = 2'd0,
    CMD_ADD_MNT = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_QUERY  = 2'd0,
    ST_ADDED  = 2'd1,
    ST_BADLEN = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    POL_ALLOW_ALL   = 2'd0,
    POL_ALLOW_LIST  = 2'd1,
    POL_BLOCK_LIST  = 2'd2,
    POL_UNDEF       = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    REG_ACTIVE_MODE = 2'd0,
    REG_SVC_TYPE    = 2'd1,
    REG_MNT_TYPE    = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } fsm_e;

endpackage

/* src/address_prefix_access_filter_unit.sv */
// ----------------------------------------------------------------------------
// address_prefix_access_filter_unit
// two prefix lists in one entry memory, scanned one entry per cycle on query
// ----------------------------------------------------------------------------
//  channel   dir  beat                 payload
//  s_axis    in   command              tuser: cmd; tdata: head, tail, length
//  m_axis    out  verdict              tuser: status; tdata: allowed
//  cfg       in   register write       index, data
//
//  add: entry written on accept; the done state then loads the result beat
//  query: one entry memory read per cycle while the scan state walks the list
//  reset clears counts and registers; entry memory holds no reset value
//  the result waits in an output register; the next item is taken once the
//  scan sequencer is back idle
// ----------------------------------------------------------------------------
module address_prefix_access_filter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // text_head [63:0], text_tail [119:64], text_length [124:120], zero pad
  input  logic [apaf_pkg::InDataW-1:0]   s_axis_tdata_i,
  // cmd [1:0]
  input  logic [1:0]                     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // allowed [0], zero pad
  output logic [apaf_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // status [1:0]
  output logic [1:0]                     m_axis_tuser_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [apaf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [apaf_pkg::CfgDatW-1:0]   cfg_data_i
);
  import apaf_pkg::*;

  fsm_e                state_q, state_d;
  logic                mode_q;
  policy_e             svc_type_q, mnt_type_q;
  logic [CntW-1:0]     svc_cnt_q, mnt_cnt_q;
  logic [EntryW-1:0]   mem_q [Slots];
  logic [EntryW-1:0]   rd_data_q;
  logic                rd_vld_q;
  logic [SlotW-1:0]    base_q;
  logic [CntW-1:0]     scan_cnt_q, k_q;
  logic                block_q, hit_q;
  logic [TextW-1:0]    qtext_q;
  logic [ELenW-1:0]    qlen_q;
  logic                res_allowed_q;
  status_e             res_status_q;
  logic                m_valid_q, m_allowed_q;
  status_e             m_status_q;

  logic                s_tready, acc, rd_en, load_out, scan_end, match, len_ok, add_svc;
  logic                wr_en;
  logic [SlotW-1:0]    wr_addr, rd_addr;
  cmd_e                cmd;
  logic [TextW-1:0]    in_text;
  logic [LenW-1:0]     in_len;
  policy_e             q_type;
  logic [CntW-1:0]     q_cnt, a_cnt;
  logic [TextW-1:0]    e_text;
  logic [ELenW-1:0]    e_len;
  logic [MAX_TEXT_CHARS-1:0] ch_ok;

  assign cmd     = cmd_e'(s_axis_tuser_i);
  assign in_text = {s_axis_tdata_i[HeadW-1:0], s_axis_tdata_i[HeadW+TailW-1:HeadW]};
  assign in_len  = s_axis_tdata_i[HeadW+TailW+LenW-1:HeadW+TailW];
  assign len_ok  = (in_len != '0) && (in_len <= LenW'(MAX_TEXT_CHARS));
  assign acc     = s_axis_tvalid_i && s_tready;
  assign add_svc = (cmd == CMD_ADD_SVC);
  assign a_cnt   = add_svc ? svc_cnt_q : mnt_cnt_q;
  assign q_type  = mode_q ? mnt_type_q : svc_type_q;
  assign q_cnt   = mode_q ? mnt_cnt_q : svc_cnt_q;
  assign wr_en   = acc && (cmd == CMD_ADD_SVC || cmd == CMD_ADD_MNT) && len_ok
                   && (a_cnt < CntW'(LIST_DEPTH));
  assign wr_addr = (add_svc ? '0 : SlotW'(LIST_DEPTH)) + SlotW'(a_cnt);
  assign rd_addr = base_q + SlotW'(k_q);
  assign scan_end = (k_q == scan_cnt_q) && !rd_vld_q;

  // prefix compare of the entry just read
  assign e_text = rd_data_q[TextW-1:0];
  assign e_len  = rd_data_q[EntryW-1:TextW];
  always_comb begin
    for (int i = 0; i < MAX_TEXT_CHARS; i++) begin
      ch_ok[i] = (e_text[TextW-1-8*i -: 8] == qtext_q[TextW-1-8*i -: 8])
                 || (ELenW'(i) >= e_len);
    end
  end
  assign match = (e_len != '0) && (e_len <= qlen_q) && (&ch_ok);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (acc) begin
          if (cmd == CMD_QUERY && q_type != POL_ALLOW_ALL && q_cnt != '0 && len_ok) begin
            state_d = FSM_SCAN;
          end else begin
            state_d = FSM_DONE;
          end
        end
      end
      FSM_SCAN: begin
        if (scan_end) state_d = FSM_DONE;
      end
      FSM_DONE: begin
        if (!m_valid_q || m_axis_tready_i) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      FSM_IDLE: s_tready = 1'b1;
      FSM_SCAN: rd_en    = (k_q != scan_cnt_q);
      FSM_DONE: load_out = !m_valid_q || m_axis_tready_i;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FSM_IDLE;
      mode_q     <= 1'b0;
      svc_type_q <= POL_ALLOW_ALL;
      mnt_type_q <= POL_ALLOW_ALL;
      svc_cnt_q  <= '0;
      mnt_cnt_q  <= '0;
      rd_vld_q   <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (cfg_valid_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_ACTIVE_MODE: mode_q <= cfg_data_i[0];
          REG_SVC_TYPE: if (policy_e'(cfg_data_i) != POL_UNDEF) svc_type_q <= policy_e'(cfg_data_i);
          REG_MNT_TYPE: if (policy_e'(cfg_data_i) != POL_UNDEF) mnt_type_q <= policy_e'(cfg_data_i);
          default: ;
        endcase
      end
      if (wr_en) begin
        if (add_svc) svc_cnt_q <= svc_cnt_q + 1'b1;
        else         mnt_cnt_q <= mnt_cnt_q + 1'b1;
      end
      if (load_out)             m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;
    end
  end

  // item and scan datapath
  always_ff @(posedge clk_i) begin
    if (acc) begin
      qtext_q    <= in_text;
      qlen_q     <= in_len[ELenW-1:0];
      base_q     <= mode_q ? SlotW'(LIST_DEPTH) : '0;
      scan_cnt_q <= q_cnt;
      k_q        <= '0;
      block_q    <= (q_type == POL_BLOCK_LIST);
      hit_q      <= 1'b0;
      res_allowed_q <= 1'b0;
      case (cmd)
        CMD_ADD_SVC, CMD_ADD_MNT: begin
          if (!len_ok)                         res_status_q <= ST_BADLEN;
          else if (a_cnt >= CntW'(LIST_DEPTH)) res_status_q <= ST_FULL;
          else                                 res_status_q <= ST_ADDED;
        end
        CMD_QUERY: begin
          res_status_q  <= ST_QUERY;
          res_allowed_q <= (q_type == POL_ALLOW_ALL) || (q_cnt == '0);
        end
        default: res_status_q <= ST_BADLEN;
      endcase
    end
    if (rd_en) k_q <= k_q + 1'b1;
    if (rd_vld_q && match) hit_q <= 1'b1;
    if (state_q == FSM_SCAN && scan_end) res_allowed_q <= block_q ? !hit_q : hit_q;
    if (load_out) begin
      m_allowed_q <= res_allowed_q;
      m_status_q  <= res_status_q;
    end
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= {in_len[ELenW-1:0], in_text};
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  assign s_axis_tready_o = s_tready;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-1){1'b0}}, m_allowed_q};
  assign m_axis_tuser_o  = m_status_q;
  assign cfg_ready_o     = 1'b1;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    svc_cnt_q <= CntW'(LIST_DEPTH) && mnt_cnt_q <= CntW'(LIST_DEPTH))
    else $error("list count above depth");

  a_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == FSM_IDLE)
    else $error("entry write outside idle");

  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> k_q < scan_cnt_q)
    else $error("scan read beyond list count");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (svc_cnt_q != $past(svc_cnt_q)) |-> $past(wr_en && add_svc))
    else $error("service count moved without an add");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the address prefix access filter unit
// ----------------------------------------------------------------------------
// A short directed table covers length limits, unused commands, each policy,
// an ignored policy code and a mode switch. Random phases follow, each one
// starting from a new register setting. Most queries are built from prefixes
// already stored in the active list, so the scan finds hits and near misses.
// Every result beat is checked against a tabled verdict or an in-bench prediction.
// ----------------------------------------------------------------------------
module tb;
  import apaf_pkg::*;

  typedef struct packed {
    logic    allowed;
    status_e status;
  } verdict_t;

  typedef struct {
    bit           is_cfg;
    reg_idx_e     idx;
    logic [1:0]   val;
    cmd_e         cmd;
    logic [119:0] text;
    logic [4:0]   len;
    bit           typed;
    verdict_t     want;
  } plan_row_t;

  localparam int unsigned PhaseItems = 150;
  localparam int unsigned Phases     = 9;

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [InDataW-1:0]    s_axis_tdata_i  = '0;
  logic [1:0]            s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata_o;
  logic [1:0]            m_axis_tuser_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i     = '0;
  logic [CfgDatW-1:0]    cfg_data_i      = '0;

  // filter state as predicted
  logic [119:0] stored_text [Slots];
  logic [4:0]   stored_len  [Slots];
  int unsigned  list_count  [2] = '{0, 0};
  policy_e      list_policy [2] = '{POL_ALLOW_ALL, POL_ALLOW_ALL};
  logic         active_list = 1'b0;

  verdict_t  pending_verdicts [$];
  plan_row_t plan [$];
  bit        steady = 1'b0;
  int        errors = 0;
  int        n_results = 0, n_added = 0, n_full = 0, n_passed = 0, n_refused = 0;
  int        n_writes = 0;

  address_prefix_access_filter_unit uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic bit prefix_hit(logic [119:0] entry, logic [4:0] elen,
                                    logic [119:0] query, logic [4:0] qlen);
    if (elen > qlen) return 1'b0;
    for (int i = 0; i < elen; i++)
      if (entry[119-8*i -: 8] != query[119-8*i -: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic verdict_t filter_command(cmd_e cmd, logic [119:0] text,
                                              logic [4:0] len);
    verdict_t v;
    int       list;
    bit       hit;
    v.allowed = 1'b0;
    v.status  = ST_BADLEN;
    case (cmd)
      CMD_ADD_SVC, CMD_ADD_MNT: begin
        list = (cmd == CMD_ADD_MNT);
        if (len < 1 || len > MAX_TEXT_CHARS) begin
          v.status = ST_BADLEN;
        end else if (list_count[list] >= LIST_DEPTH) begin
          v.status = ST_FULL;
          n_full++;
        end else begin
          stored_text[list*LIST_DEPTH + list_count[list]] = text;
          stored_len[list*LIST_DEPTH + list_count[list]]  = len;
          list_count[list]++;
          v.status = ST_ADDED;
          n_added++;
        end
      end
      CMD_QUERY: begin
        list     = active_list;
        v.status = ST_QUERY;
        if (list_policy[list] == POL_ALLOW_ALL || list_count[list] == 0) begin
          v.allowed = 1'b1;
        end else if (len < 1 || len > MAX_TEXT_CHARS) begin
          v.allowed = 1'b0;
        end else begin
          hit = 1'b0;
          for (int k = 0; k < list_count[list]; k++)
            if (prefix_hit(stored_text[list*LIST_DEPTH + k],
                           stored_len[list*LIST_DEPTH + k], text, len))
              hit = 1'b1;
          v.allowed = (list_policy[list] == POL_ALLOW_LIST) ? hit : !hit;
        end
        if (v.allowed) n_passed++;
        else n_refused++;
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic plan_row_t item_row(cmd_e cmd, logic [119:0] text, logic [4:0] len,
                                         bit typed = 1'b0, logic allowed = 1'b0,
                                         status_e st = ST_QUERY);
    plan_row_t r;
    r.is_cfg       = 1'b0;
    r.idx          = REG_UNUSED;
    r.val          = '0;
    r.cmd          = cmd;
    r.text         = text;
    r.len          = len;
    r.typed        = typed;
    r.want.allowed = allowed;
    r.want.status  = st;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(reg_idx_e idx, logic [1:0] val);
    plan_row_t r;
    r        = item_row(CMD_NONE, '0, '0);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  function automatic void add_row(plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  function automatic logic [7:0] pick_char(bit narrow);
    return narrow ? 8'(8'h61 + $urandom_range(2)) : 8'($urandom_range(255));
  endfunction

  function automatic logic [119:0] random_text(bit narrow);
    logic [119:0] t;
    for (int i = 0; i < MAX_TEXT_CHARS; i++) t[119-8*i -: 8] = pick_char(narrow);
    return t;
  endfunction

  function automatic logic [4:0] bad_length();
    return $urandom_range(1) ? 5'd0 : 5'($urandom_range(16, 31));
  endfunction

  task automatic send_command(cmd_e cmd, logic [119:0] text, logic [4:0] len,
                              bit typed, verdict_t typed_verdict);
    verdict_t v;
    if (!steady) begin
      while ($urandom_range(99) < 9) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, len, text[55:0], text[119:56]};
    s_axis_tuser_i  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    v = filter_command(cmd, text, len);
    pending_verdicts.insert(pending_verdicts.size(), typed ? typed_verdict : v);
  endtask

  task automatic wait_for_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // leaves valid high so that writes can follow back to back
  task automatic write_reg(reg_idx_e idx, logic [1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    n_writes++;
    case (idx)
      REG_ACTIVE_MODE: active_list = val[0];
      REG_SVC_TYPE:    if (val != POL_UNDEF) list_policy[0] = policy_e'(val);
      REG_MNT_TYPE:    if (val != POL_UNDEF) list_policy[1] = policy_e'(val);
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : verdict_check
    verdict_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_results++;
      if (pending_verdicts.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata_o[0] !== want.allowed) begin
          $error("allowed: expected %0d, got %0d", want.allowed, m_axis_tdata_o[0]);
          errors++;
        end
        if (m_axis_tuser_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser_o);
          errors++;
        end
      end
    end
    m_axis_tready_i <= rst_ni && (steady || $urandom_range(99) >= 9);
  end

  initial begin : stimulus
    verdict_t     none;
    cmd_e         cmd;
    logic [119:0] text;
    logic [4:0]   len;
    int           slot, pos, r;
    none = '0;

    // directed part
    add_row(item_row(CMD_QUERY, '1, 5'd31, 1'b1, 1'b1, ST_QUERY));
    add_row(cfg_row(REG_SVC_TYPE, POL_ALLOW_LIST));
    add_row(item_row(CMD_QUERY, '0, 5'd0, 1'b1, 1'b1, ST_QUERY));
    add_row(item_row(CMD_ADD_SVC, '1, 5'd0, 1'b1, 1'b0, ST_BADLEN));
    add_row(item_row(CMD_ADD_SVC, '1, 5'd16, 1'b1, 1'b0, ST_BADLEN));
    add_row(item_row(CMD_ADD_MNT, '0, 5'd31, 1'b1, 1'b0, ST_BADLEN));
    add_row(item_row(CMD_NONE, '1, 5'd5, 1'b1, 1'b0, ST_BADLEN));
    add_row(item_row(CMD_ADD_SVC, {16'h6162, {13{8'hc3}}}, 5'd2,
                     1'b1, 1'b0, ST_ADDED));
    add_row(item_row(CMD_ADD_SVC, '1, 5'd15, 1'b1, 1'b0, ST_ADDED));
    add_row(item_row(CMD_ADD_MNT, '0, 5'd15, 1'b1, 1'b0, ST_ADDED));
    add_row(item_row(CMD_ADD_MNT, {8'h7a, {14{8'h55}}}, 5'd1,
                     1'b1, 1'b0, ST_ADDED));
    add_row(item_row(CMD_QUERY, {24'h616263, {12{8'h99}}}, 5'd3));
    add_row(item_row(CMD_QUERY, {16'h6163, {13{8'h62}}}, 5'd2));
    add_row(item_row(CMD_QUERY, {8'h61, {14{8'h62}}}, 5'd1));
    add_row(item_row(CMD_QUERY, '1, 5'd15));
    add_row(item_row(CMD_QUERY, '1, 5'd0, 1'b1, 1'b0, ST_QUERY));
    add_row(item_row(CMD_QUERY, '1, 5'd16, 1'b1, 1'b0, ST_QUERY));
    add_row(cfg_row(REG_SVC_TYPE, POL_BLOCK_LIST));
    add_row(item_row(CMD_QUERY, {24'h616263, {12{8'h00}}}, 5'd3));
    add_row(item_row(CMD_QUERY, {8'h78, {14{8'h61}}}, 5'd1));
    // undefined policy code leaves the block policy in place
    add_row(cfg_row(REG_SVC_TYPE, POL_UNDEF));
    add_row(item_row(CMD_QUERY, {24'h616263, {12{8'hff}}}, 5'd3));
    add_row(cfg_row(REG_ACTIVE_MODE, 2'd1));
    add_row(cfg_row(REG_MNT_TYPE, POL_ALLOW_LIST));
    add_row(item_row(CMD_QUERY, {32'h7a7a7a7a, {11{8'h01}}}, 5'd4));
    add_row(item_row(CMD_QUERY, '0, 5'd15));
    add_row(item_row(CMD_QUERY, '0, 5'd14));
    add_row(cfg_row(REG_UNUSED, 2'd3));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_for_idle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        if (cfg_valid_i) cfg_valid_i <= 1'b0;
        send_command(plan[i].cmd, plan[i].text, plan[i].len, plan[i].typed, plan[i].want);
      end
    end

    // random phases, each from a fresh register setting
    for (int p = 0; p < Phases; p++) begin
      wait_for_idle();
      write_reg(REG_ACTIVE_MODE, 2'(p % 2));
      write_reg(REG_SVC_TYPE, 2'((p / 2) % 3));
      write_reg(REG_MNT_TYPE, 2'(((p + 1) / 2) % 3));
      if ($urandom_range(2) == 0)
        write_reg($urandom_range(1) ? REG_SVC_TYPE : REG_MNT_TYPE, POL_UNDEF);
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, 2'($urandom_range(3)));
      cfg_valid_i <= 1'b0;
      steady = (p == 4);

      for (int n = 0; n < PhaseItems; n++) begin
        r = $urandom_range(99);
        if (r < 20) begin
          cmd  = (r < 10) ? CMD_ADD_SVC : CMD_ADD_MNT;
          text = random_text($urandom_range(1));
          len  = ($urandom_range(9) == 0) ? bad_length()
                                          : 5'($urandom_range(1, $urandom_range(1, 15)));
        end else if (r < 24) begin
          cmd  = CMD_NONE;
          text = random_text(1'b0);
          len  = 5'($urandom_range(31));
        end else begin
          cmd  = CMD_QUERY;
          text = random_text($urandom_range(1));
          len  = 5'($urandom_range(1, 15));
          if (list_count[active_list] != 0 && $urandom_range(99) < 65) begin
            // extend a stored prefix, sometimes spoil or shorten it
            slot = active_list * LIST_DEPTH + $urandom_range(list_count[active_list] - 1);
            len  = 5'($urandom_range(stored_len[slot], 15));
            for (int i = 0; i < stored_len[slot]; i++)
              text[119-8*i -: 8] = stored_text[slot][119-8*i -: 8];
            if ($urandom_range(3) == 0) begin
              pos = $urandom_range(len - 1);
              text[119-8*pos -: 8] = pick_char($urandom_range(1));
            end
            if ($urandom_range(7) == 0) len = stored_len[slot] - 5'd1;
          end
          if ($urandom_range(9) == 0) len = bad_length();
        end
        send_command(cmd, text, len, 1'b0, none);
      end
    end
    steady = 1'b0;

    wait_for_idle();
    repeat (30) @(posedge clk_i);
    $display("%0d results checked: %0d entries stored, %0d adds to a full list",
             n_results, n_added, n_full);
    $display("%0d queries passed, %0d refused, %0d register writes",
             n_passed, n_refused, n_writes);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
src/apaf_pkg.sv
src/address_prefix_access_filter_unit.sv
verif/tb.sv
